// ===== rtl/core/number_to_text_formatter_unit_defines.svh =====
// Assertion helpers for the number-to-text formatter.
// Sampled on i_clk and held off while i_rst_n is low.
`ifndef NUMBER_TO_TEXT_FORMATTER_UNIT_DEFINES_SVH
`define NUMBER_TO_TEXT_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define NTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define NTF_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`else

`define NTF_ASSERT(lbl, prop, msg)

`define NTF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/ntf_pkg.sv =====
package ntf_pkg;

    localparam int VAL_W = 10;
    localparam int FMT_W = 4;
    localparam int POS_W = 6;

    typedef struct packed {
        logic [VAL_W-1:0] number_value;
        logic [FMT_W-1:0] number_format;
    } t_in_word;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_out_word;

    // result of the subtract unit
    typedef struct packed {
        logic       dig_th;
        logic [3:0] dig_h;
        logic [3:0] dig_t;
        logic [3:0] dig_o;
        logic [5:0] quo;
        logic [4:0] let_idx;
    } t_conv;

    localparam logic [FMT_W-1:0] FMT_UPPER_LETTERS = 4'd0;
    localparam logic [FMT_W-1:0] FMT_LOWER_LETTERS = 4'd1;
    localparam logic [FMT_W-1:0] FMT_DECIMAL       = 4'd2;
    localparam logic [FMT_W-1:0] FMT_DASHED        = 4'd3;
    localparam logic [FMT_W-1:0] FMT_CIRCLED       = 4'd4;
    localparam logic [FMT_W-1:0] FMT_PERIOD        = 4'd5;
    localparam logic [FMT_W-1:0] FMT_PAREN         = 4'd6;
    localparam logic [FMT_W-1:0] FMT_HEX           = 4'd7;
    localparam logic [FMT_W-1:0] FMT_ORDINAL       = 4'd8;
    localparam logic [FMT_W-1:0] FMT_UPPER_ROMAN   = 4'd9;
    localparam logic [FMT_W-1:0] FMT_LOWER_ROMAN   = 4'd10;

    localparam logic [VAL_W-1:0] DIV_LETTER = 10'd26;
    localparam logic [VAL_W-1:0] DIV_THOU   = 10'd1000;
    localparam logic [VAL_W-1:0] DIV_HUND   = 10'd100;
    localparam logic [VAL_W-1:0] DIV_TENS   = 10'd10;

    localparam logic [1:0] STG_THOU = 2'd0;
    localparam logic [1:0] STG_HUND = 2'd1;
    localparam logic [1:0] STG_TENS = 2'd2;

    localparam logic [7:0] ENC_LEAD      = 8'hE2;
    localparam logic [7:0] ENC_MID_A     = 8'h91;
    localparam logic [7:0] ENC_MID_B     = 8'h92;
    localparam logic [7:0] CIRCLED_BASE  = 8'h9F;
    localparam logic [7:0] PERIOD_BASE   = 8'h87;
    localparam logic [7:0] PAREN_LO_BASE = 8'hB3;
    localparam logic [7:0] PAREN_HI_BASE = 8'h73;
    localparam logic [VAL_W-1:0] PAREN_SPLIT = 10'd12;
    localparam logic [VAL_W-1:0] ENC_MAX     = 10'd20;

    localparam logic [POS_W-1:0] MAX_BYTES = 6'd40;
    localparam logic [7:0] LOWER_BIT = 8'h20;

    localparam logic [1:0] PLACE_ONES  = 2'd0;
    localparam logic [1:0] PLACE_TENS  = 2'd1;
    localparam logic [1:0] PLACE_HUNDS = 2'd2;

    localparam logic [1:0] SYM_ONE  = 2'd0;
    localparam logic [1:0] SYM_FIVE = 2'd1;
    localparam logic [1:0] SYM_TEN  = 2'd2;

    function automatic logic is_letters(input logic [FMT_W-1:0] fmt,
                                        input logic [VAL_W-1:0] val);
        return (fmt == FMT_UPPER_LETTERS || fmt == FMT_LOWER_LETTERS) && (val != '0);
    endfunction

    function automatic logic [2:0] roman_len(input logic [3:0] d);
        logic [2:0] len;
        case (d)
            4'd1, 4'd5:               len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9:   len = 3'd2;
            4'd3, 4'd7:               len = 3'd3;
            4'd8:                     len = 3'd4;
            default:                  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] roman_sym(input logic [3:0] d, input logic [1:0] k);
        logic [1:0] sym;
        if (d == 4'd4)
            sym = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
        else if (d == 4'd9)
            sym = (k == 2'd0) ? SYM_ONE : SYM_TEN;
        else if (d >= 4'd5)
            sym = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
        else
            sym = SYM_ONE;
        return sym;
    endfunction

    function automatic logic [7:0] roman_char(input logic [1:0] place, input logic [1:0] sym);
        logic [7:0] c;
        case ({place, sym})
            {PLACE_ONES,  SYM_ONE}:  c = "I";
            {PLACE_ONES,  SYM_FIVE}: c = "V";
            {PLACE_ONES,  SYM_TEN}:  c = "X";
            {PLACE_TENS,  SYM_ONE}:  c = "X";
            {PLACE_TENS,  SYM_FIVE}: c = "L";
            {PLACE_TENS,  SYM_TEN}:  c = "C";
            {PLACE_HUNDS, SYM_ONE}:  c = "C";
            {PLACE_HUNDS, SYM_FIVE}: c = "D";
            {PLACE_HUNDS, SYM_TEN}:  c = "M";
            default:                 c = "M";
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/ntf_digit_unit.sv =====
module ntf_digit_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ntf_pkg::t_in_word i_word,
    output logic             o_done,
    output ntf_pkg::t_conv   o_conv
);
    import ntf_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_letter, n_letter;
    logic [1:0]       r_stage, n_stage;
    logic [VAL_W-1:0] r_rem, n_rem;
    logic [5:0]       r_cnt, n_cnt;
    t_conv            r_conv, n_conv;

    logic [VAL_W-1:0] w_div;
    logic             w_ge;
    logic [VAL_W-1:0] w_diff;

    // shared compare/subtract
    always_comb begin
        if (r_letter) begin
            w_div = DIV_LETTER;
        end else begin
            unique case (r_stage)
                STG_THOU: w_div = DIV_THOU;
                STG_HUND: w_div = DIV_HUND;
                default:  w_div = DIV_TENS;
            endcase
        end
        w_ge   = (r_rem >= w_div);
        w_diff = r_rem - w_div;
    end

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_letter = r_letter;
        n_stage  = r_stage;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_conv   = r_conv;
        if (i_start) begin
            n_busy   = 1'b1;
            n_letter = is_letters(i_word.number_format, i_word.number_value);
            n_rem    = n_letter ? (i_word.number_value - 10'd1) : i_word.number_value;
            n_stage  = STG_THOU;
            n_cnt    = '0;
        end else if (r_busy) begin
            if (w_ge) begin
                n_rem = w_diff;
                n_cnt = r_cnt + 6'd1;
            end else if (r_letter) begin
                n_conv.quo     = r_cnt;
                n_conv.let_idx = r_rem[4:0];
                n_busy         = 1'b0;
                n_done         = 1'b1;
            end else begin
                n_cnt = '0;
                unique case (r_stage)
                    STG_THOU: begin
                        n_conv.dig_th = r_cnt[0];
                        n_stage       = STG_HUND;
                    end
                    STG_HUND: begin
                        n_conv.dig_h = r_cnt[3:0];
                        n_stage      = STG_TENS;
                    end
                    default: begin
                        n_conv.dig_t = r_cnt[3:0];
                        n_conv.dig_o = r_rem[3:0];
                        n_busy       = 1'b0;
                        n_done       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_letter <= n_letter;
        r_stage  <= n_stage;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_conv   <= n_conv;
    end

    assign o_done = r_done;
    assign o_conv = r_conv;

endmodule

// ===== rtl/core/ntf_byte_gen.sv =====
module ntf_byte_gen (
    input  logic [ntf_pkg::VAL_W-1:0] i_value,
    input  logic [ntf_pkg::FMT_W-1:0] i_format,
    input  ntf_pkg::t_conv            i_conv,
    input  logic [ntf_pkg::POS_W-1:0] i_pos,
    output logic [7:0]                o_byte,
    output logic [ntf_pkg::POS_W-1:0] o_len
);
    import ntf_pkg::*;

    logic             w_nonzero;
    logic [2:0]       w_ndig;
    logic [POS_W-1:0] w_ndig6;
    logic [POS_W-1:0] w_rel;
    logic [2:0]       w_didx;
    logic [3:0]       w_digit;
    logic [7:0]       w_dchar;
    logic [1:0]       w_nhex;
    logic [1:0]       w_hidx;
    logic [3:0]       w_nib;
    logic [7:0]       w_hchar;
    logic [7:0]       w_suf0, w_suf1;
    logic             w_enc_ok;
    logic [7:0]       w_enc_mid, w_enc_low;
    logic [7:0]       w_n8;
    logic [POS_W-1:0] w_b1, w_b2, w_b3, w_b4;
    logic [POS_W-1:0] w_o1, w_o2, w_o3;
    logic [7:0]       w_roman;

    assign w_nonzero = (i_value != '0);
    assign w_n8      = {3'b000, i_value[4:0]};

    // decimal digit selection
    always_comb begin
        if (i_conv.dig_th)
            w_ndig = 3'd4;
        else if (i_conv.dig_h != 4'd0)
            w_ndig = 3'd3;
        else if (i_conv.dig_t != 4'd0)
            w_ndig = 3'd2;
        else
            w_ndig = 3'd1;
        w_ndig6 = {3'b000, w_ndig};
        w_rel   = (i_format == FMT_DASHED) ? (i_pos - 6'd2) : i_pos;
        w_didx  = w_ndig - 3'd1 - w_rel[2:0];
        case (w_didx)
            3'd3:    w_digit = {3'b000, i_conv.dig_th};
            3'd2:    w_digit = i_conv.dig_h;
            3'd1:    w_digit = i_conv.dig_t;
            default: w_digit = i_conv.dig_o;
        endcase
        w_dchar = 8'h30 + {4'h0, w_digit};
    end

    // hex nibble selection, no leading zeros
    always_comb begin
        if (i_value[9:8] != 2'b00)
            w_nhex = 2'd3;
        else if (i_value[7:4] != 4'h0)
            w_nhex = 2'd2;
        else
            w_nhex = 2'd1;
        w_hidx = w_nhex - 2'd1 - i_pos[1:0];
        case (w_hidx)
            2'd2:    w_nib = {2'b00, i_value[9:8]};
            2'd1:    w_nib = i_value[7:4];
            default: w_nib = i_value[3:0];
        endcase
        w_hchar = (w_nib < 4'd10) ? (8'h30 + {4'h0, w_nib}) : (8'h37 + {4'h0, w_nib});
    end

    // ordinal suffix; teens take "th"
    always_comb begin
        w_suf0 = "t";
        w_suf1 = "h";
        if (i_conv.dig_t != 4'd1) begin
            case (i_conv.dig_o)
                4'd1: begin
                    w_suf0 = "s";
                    w_suf1 = "t";
                end
                4'd2: begin
                    w_suf0 = "n";
                    w_suf1 = "d";
                end
                4'd3: begin
                    w_suf0 = "r";
                    w_suf1 = "d";
                end
                default: begin
                    w_suf0 = "t";
                    w_suf1 = "h";
                end
            endcase
        end
    end

    // enclosed numerals
    always_comb begin
        w_enc_ok  = w_nonzero && (i_value <= ENC_MAX);
        w_enc_mid = ENC_MID_A;
        w_enc_low = CIRCLED_BASE + w_n8;
        case (i_format)
            FMT_PERIOD: begin
                w_enc_mid = ENC_MID_B;
                w_enc_low = PERIOD_BASE + w_n8;
            end
            FMT_PAREN: begin
                if (i_value <= PAREN_SPLIT) begin
                    w_enc_mid = ENC_MID_A;
                    w_enc_low = PAREN_LO_BASE + w_n8;
                end else begin
                    w_enc_mid = ENC_MID_B;
                    w_enc_low = PAREN_HI_BASE + w_n8;
                end
            end
            default: begin
                w_enc_mid = ENC_MID_A;
                w_enc_low = CIRCLED_BASE + w_n8;
            end
        endcase
    end

    // roman: optional M, then hundreds, tens, ones groups
    always_comb begin
        w_b1 = {5'b00000, i_conv.dig_th};
        w_b2 = w_b1 + {3'b000, roman_len(i_conv.dig_h)};
        w_b3 = w_b2 + {3'b000, roman_len(i_conv.dig_t)};
        w_b4 = w_b3 + {3'b000, roman_len(i_conv.dig_o)};
        w_o1 = i_pos - w_b1;
        w_o2 = i_pos - w_b2;
        w_o3 = i_pos - w_b3;
        if (i_pos < w_b1)
            w_roman = "M";
        else if (i_pos < w_b2)
            w_roman = roman_char(PLACE_HUNDS, roman_sym(i_conv.dig_h, w_o1[1:0]));
        else if (i_pos < w_b3)
            w_roman = roman_char(PLACE_TENS, roman_sym(i_conv.dig_t, w_o2[1:0]));
        else
            w_roman = roman_char(PLACE_ONES, roman_sym(i_conv.dig_o, w_o3[1:0]));
    end

    always_comb begin
        o_byte = w_dchar;
        o_len  = w_ndig6;
        unique case (i_format) inside
            FMT_UPPER_LETTERS, FMT_LOWER_LETTERS: begin
                if (w_nonzero) begin
                    o_byte = ((i_format == FMT_UPPER_LETTERS) ? 8'h41 : 8'h61)
                             + {3'b000, i_conv.let_idx};
                    o_len  = i_conv.quo + 6'd1;
                end
            end
            FMT_DASHED: begin
                o_len = w_ndig6 + 6'd4;
                if (i_pos < 6'd2)
                    o_byte = i_pos[0] ? " " : "-";
                else if (i_pos < w_ndig6 + 6'd2)
                    o_byte = w_dchar;
                else
                    o_byte = (i_pos == w_ndig6 + 6'd2) ? " " : "-";
            end
            FMT_CIRCLED, FMT_PERIOD, FMT_PAREN: begin
                if (w_enc_ok) begin
                    o_len = 6'd3;
                    if (i_pos == 6'd0)
                        o_byte = ENC_LEAD;
                    else if (i_pos == 6'd1)
                        o_byte = w_enc_mid;
                    else
                        o_byte = w_enc_low;
                end
            end
            FMT_HEX: begin
                o_len  = {4'h0, w_nhex};
                o_byte = w_hchar;
            end
            FMT_ORDINAL: begin
                o_len = w_ndig6 + 6'd2;
                if (i_pos < w_ndig6)
                    o_byte = w_dchar;
                else
                    o_byte = (i_pos == w_ndig6) ? w_suf0 : w_suf1;
            end
            FMT_UPPER_ROMAN, FMT_LOWER_ROMAN: begin
                if (w_nonzero) begin
                    o_len  = w_b4;
                    o_byte = (i_format == FMT_LOWER_ROMAN) ? (w_roman | LOWER_BIT) : w_roman;
                end
            end
            default: begin
                o_byte = w_dchar;
                o_len  = w_ndig6;
            end
        endcase
    end

endmodule

// ===== rtl/core/number_to_text_formatter_unit.sv =====
// Number-to-text formatter.
// Input channel (i_in_valid / o_in_ready / i_in_word): one word carries a
// page number (0..1023) and a format code. Output channel (o_out_valid /
// i_out_ready / o_out_word): one text byte per word, last_byte set on the
// final byte of the number's text. A number yields 1 to 40 bytes.
// Per number: an accept step, then a conversion pass through a single
// compare/subtract unit that subtracts each divisor repeatedly: divisors
// 1000, 100 and 10 for the decimal-based formats and divisor 26 for the
// letter formats, then a registered hand-over of the result. Then one
// byte per cycle into the output register while the receiver keeps up.
// o_in_ready is high only while the block is idle; the next number may be
// taken while the final byte still sits in the output register.
// A stalled receiver holds the output register and freezes byte emission;
// nothing is dropped. Reset (synchronous, active low) returns to idle and
// empties the output register.
`include "number_to_text_formatter_unit_defines.svh"

module number_to_text_formatter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ntf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ntf_pkg::t_out_word o_out_word
);
    import ntf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0] r_value;
    logic [FMT_W-1:0] r_format;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             w_in_accept;
    logic             w_conv_done;
    t_conv            w_conv;
    logic [7:0]       w_byte;
    logic [POS_W-1:0] w_len;
    logic             w_last;
    logic             w_out_free;
    logic             w_load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;

    // repeated-subtraction digit / letter-count extraction
    ntf_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_accept),
        .i_word  (i_in_word),
        .o_done  (w_conv_done),
        .o_conv  (w_conv)
    );

    // byte at the current position, and total text length
    ntf_byte_gen u_byte (
        .i_value  (r_value),
        .i_format (r_format),
        .i_conv   (w_conv),
        .i_pos    (r_pos),
        .o_byte   (w_byte),
        .o_len    (w_len)
    );

    // output register takes a new byte when empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = (r_state == ST_EMIT) && w_out_free;
    assign w_last     = ((r_pos + 6'd1) == w_len);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept)
                    n_state = ST_CONV;
            end
            ST_CONV: begin
                if (w_conv_done) begin
                    n_state = ST_EMIT;
                    n_pos   = '0;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_pos = r_pos + 6'd1;
                    if (w_last)
                        n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (w_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
        if (w_in_accept) begin
            r_value  <= i_in_word.number_value;
            r_format <= i_in_word.number_format;
        end
        if (w_load) begin
            r_out_word.text_byte <= w_byte;
            r_out_word.last_byte <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // conversion finishes only while waiting on it
    `NTF_ASSERT(a_done_in_conv, w_conv_done |-> (r_state == ST_CONV), "conversion done outside CONV")
    // every text is 1..40 bytes long
    `NTF_ASSERT(a_len_range, (r_state == ST_EMIT) |-> ((w_len != 6'd0) && (w_len <= MAX_BYTES)), "text length out of range")
    // position never runs past the text
    `NTF_ASSERT(a_pos_bound, (r_state == ST_EMIT) |-> (r_pos < w_len), "emit position past end of text")
    // the last byte returns the block to idle
    `NTF_ASSERT(a_last_idle, (w_load && w_last) |=> (r_state == ST_IDLE), "no return to idle after last byte")
    // no byte emitted while converting or idle
    `NTF_ASSERT_NEVER(a_no_early_load, w_load && (r_state != ST_EMIT), "byte loaded outside EMIT")

endmodule
